// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, held off while reset is active.
`define CHK_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Same, with the consequence checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gpf_pkg.sv
`timescale 1ns / 1ps

package gpf_pkg;

    localparam int IN_WIDTH        = 20;
    localparam int STATUS_WIDTH    = 2;
    localparam int SMALL_WIDTH     = 19;
    localparam int LARGE_WIDTH     = 20;
    localparam int IN_TDATA_WIDTH  = 24;
    localparam int OUT_TDATA_WIDTH = 48;

    localparam logic [STATUS_WIDTH-1:0] ST_FOUND   = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_NONE    = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_INVALID = 2'd2;

    // remainder unit back to the sequencer
    typedef struct packed {
        logic done;
        logic zero;
    } rem_stat_t;

    // sequencer back to the top level
    typedef struct packed {
        logic idle;
        logic res_valid;
    } ctrl_stat_t;

endpackage

// File: hw/rtl/gpf_rem_unit.sv
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per cycle.
module gpf_rem_unit #(
    parameter int VALUE_BITS = 20
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VALUE_BITS-1:0]    dividend,
    input  logic [VALUE_BITS-1:0]    divisor,
    output gpf_pkg::rem_stat_t       stat
);
    import gpf_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS:0]   rem_reg, rem_next;
    logic [VALUE_BITS-1:0] div_reg, div_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   div_ext;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        div_ext   = {1'b0, div_reg};
        trial     = {rem_reg[VALUE_BITS-1:0], quo_reg[VALUE_BITS-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_BITS);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            rem_next = (trial >= div_ext) ? (trial - div_ext) : trial;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

// File: hw/rtl/gpf_ctrl.sv
`timescale 1ns / 1ps

// Search sequencer: walks odd p upward and trial-divides p, then n-p.
module gpf_ctrl #(
    parameter int VALUE_BITS = 20
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [VALUE_BITS-1:0]               n_in,
    input  logic                                take,
    output gpf_pkg::ctrl_stat_t                 stat,
    output logic [gpf_pkg::STATUS_WIDTH-1:0]    status,
    output logic [VALUE_BITS-1:0]               small_part,
    output logic [VALUE_BITS-1:0]               large_part
);
    import gpf_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_WAIT  = 3'd2;
    localparam logic [2:0] S_NEXT  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam logic [VALUE_BITS-1:0] MIN_N   = VALUE_BITS'(6);
    localparam logic [VALUE_BITS-1:0] FIRST_D = VALUE_BITS'(3);
    localparam logic [VALUE_BITS+1:0] FIRST_SQ = (VALUE_BITS + 2)'(9);

    logic [2:0]              state_reg, state_next;
    logic [VALUE_BITS-1:0]   n_reg, n_next;
    logic [VALUE_BITS-1:0]   p_reg, p_next;
    logic [VALUE_BITS-1:0]   cand_reg, cand_next;
    logic [VALUE_BITS-1:0]   d_reg, d_next;
    logic [VALUE_BITS+1:0]   sq_reg, sq_next;
    logic                    phase_reg, phase_next;
    logic [STATUS_WIDTH-1:0] status_reg, status_next;

    logic                    rem_start;
    rem_stat_t               rem_stat;
    logic                    sq_over;
    logic [VALUE_BITS:0]     p_plus;

    gpf_rem_unit #(
        .VALUE_BITS (VALUE_BITS)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (cand_reg),
        .divisor  (d_reg),
        .stat     (rem_stat)
    );

    // d*d > candidate ends the trial division: candidate is prime
    assign sq_over   = sq_reg > {2'b00, cand_reg};
    assign rem_start = (state_reg == S_CHECK) && !sq_over;
    assign p_plus    = {1'b0, p_reg} + (VALUE_BITS + 1)'(2);

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        p_next      = p_reg;
        cand_next   = cand_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        phase_next  = phase_reg;
        status_next = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_in;
                    p_next     = FIRST_D;
                    cand_next  = FIRST_D;
                    d_next     = FIRST_D;
                    sq_next    = FIRST_SQ;
                    phase_next = 1'b0;
                    if (n_in[0] || (n_in < MIN_N))
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (sq_over)
                begin
                    if (!phase_reg)
                    begin
                        phase_next = 1'b1;
                        cand_next  = n_reg - p_reg;
                        d_next     = FIRST_D;
                        sq_next    = FIRST_SQ;
                    end
                    else
                    begin
                        status_next = ST_FOUND;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        state_next = S_NEXT;
                    end
                    else
                    begin
                        // (d+2)^2 = d^2 + 4d + 4
                        sq_next    = sq_reg + {d_reg, 2'b00} + (VALUE_BITS + 2)'(4);
                        d_next     = d_reg + VALUE_BITS'(2);
                        state_next = S_CHECK;
                    end
                end
            end
            S_NEXT:
            begin
                d_next     = FIRST_D;
                sq_next    = FIRST_SQ;
                phase_next = 1'b0;
                if (p_plus > {2'b00, n_reg[VALUE_BITS-1:1]})
                begin
                    status_next = ST_NONE;
                    state_next  = S_DONE;
                end
                else
                begin
                    p_next     = p_plus[VALUE_BITS-1:0];
                    cand_next  = p_plus[VALUE_BITS-1:0];
                    state_next = S_CHECK;
                end
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        p_reg      <= p_next;
        cand_reg   <= cand_next;
        d_reg      <= d_next;
        sq_reg     <= sq_next;
        phase_reg  <= phase_next;
        status_reg <= status_next;
    end

    assign stat.idle      = (state_reg == S_IDLE);
    assign stat.res_valid = (state_reg == S_DONE);
    assign status         = status_reg;
    assign small_part     = (status_reg == ST_FOUND) ? p_reg : '0;
    assign large_part     = (status_reg == ST_FOUND) ? (n_reg - p_reg) : '0;

endmodule

// File: hw/rtl/goldbach_partition_finder_unit.sv
`timescale 1ns / 1ps

// Goldbach partition finder.
// Input stream s_axis: one even number per transaction in tdata[19:0]; only the
// low VALUE_BITS bits are used. Output stream m_axis: one result per input,
// status in tdata[1:0] (found / none / invalid), smaller prime in tdata[20:2],
// larger prime in tdata[40:21]; both primes read zero unless a pair is found.
// Odd numbers and numbers below 6 come back as invalid without a search.
// Otherwise odd p walks upward from 3; p and then n-p are trial-divided by
// odd d while d*d <= candidate. Every trial division runs through one shared
// bit-serial remainder unit. One item is searched at a time; s_axis_tready
// is low for the whole search.
// The finished result sits in an output register, so a new number is taken
// while the receiver still stalls; the next result then waits in the
// sequencer until the register frees up.
// Reset (rst_n, asynchronous, active low) returns the sequencer to idle and
// drops m_axis_tvalid; the datapath registers are not cleared.
module goldbach_partition_finder_unit #(
    parameter int VALUE_BITS = 20
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [19:0] even_number, [23:20] zero
    input  logic [gpf_pkg::IN_TDATA_WIDTH-1:0]      s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // [1:0] status, [20:2] smaller_prime, [40:21] larger_prime, [47:41] zero
    output logic [gpf_pkg::OUT_TDATA_WIDTH-1:0]     m_axis_tdata
);
    import gpf_pkg::*;

    `include "assert_macros.svh"

    localparam int PAD_WIDTH = OUT_TDATA_WIDTH - STATUS_WIDTH - SMALL_WIDTH - LARGE_WIDTH;

    ctrl_stat_t              ctrl_stat;
    logic                    start;
    logic                    take;
    logic [63:0]             n_ext;
    logic [VALUE_BITS-1:0]   n_in;
    logic [STATUS_WIDTH-1:0] ctrl_status;
    logic [VALUE_BITS-1:0]   ctrl_small;
    logic [VALUE_BITS-1:0]   ctrl_large;
    logic [63:0]             small_ext;
    logic [63:0]             large_ext;

    logic                    out_valid_reg, out_valid_next;
    logic [STATUS_WIDTH-1:0] out_status_reg;
    logic [SMALL_WIDTH-1:0]  out_small_reg;
    logic [LARGE_WIDTH-1:0]  out_large_reg;

    assign n_ext = 64'(s_axis_tdata[IN_WIDTH-1:0]);
    assign n_in  = n_ext[VALUE_BITS-1:0];

    assign s_axis_tready = ctrl_stat.idle;
    assign start         = s_axis_tvalid && s_axis_tready;
    assign take          = ctrl_stat.res_valid && (!out_valid_reg || m_axis_tready);

    gpf_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .n_in       (n_in),
        .take       (take),
        .stat       (ctrl_stat),
        .status     (ctrl_status),
        .small_part (ctrl_small),
        .large_part (ctrl_large)
    );

    assign small_ext = 64'(ctrl_small);
    assign large_ext = 64'(ctrl_large);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_status_reg <= ctrl_status;
            out_small_reg  <= small_ext[SMALL_WIDTH-1:0];
            out_large_reg  <= large_ext[LARGE_WIDTH-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_WIDTH{1'b0}}, out_large_reg, out_small_reg, out_status_reg};

    `CHK_NEXT(a_busy_after_accept, clk, rst_n, start, !s_axis_tready,
        "input still accepted after a transaction started a search")
    `CHK_IMPLY(a_status_code, clk, rst_n, out_valid_reg,
        out_status_reg == ST_FOUND || out_status_reg == ST_NONE ||
        out_status_reg == ST_INVALID,
        "output holds an undefined status")
    `CHK_IMPLY(a_zero_unless_found, clk, rst_n,
        out_valid_reg && out_status_reg != ST_FOUND,
        out_small_reg == '0 && out_large_reg == '0,
        "primes not zero on a result without a pair")
    `CHK_NEXT(a_result_lands, clk, rst_n, take, out_valid_reg && !ctrl_stat.res_valid,
        "taken result not in the output register")

endmodule
